### hw/rtl/life_automaton_torus_step_assert.svh
// Assertion macros shared by the life automaton RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef LIFE_AUTOMATON_TORUS_STEP_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LATS_ASSERT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LATS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lats_pkg.sv
// Shared types and constants for the life automaton torus step block.
// No dependencies; imported by the row rule, the row cell and the top level.
package lats_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;
	localparam int MIN_SIZE       = 3;
	localparam int GRID_RESET     = 64;
	localparam int BIRTH_COUNT    = 3;
	localparam int SURVIVE_COUNT  = 2;
	localparam int GEN_PERIOD     = 10;
	localparam int GEN_W          = 4;
	localparam int CFG_W          = 7;
	localparam int COORD_W        = 6;
	localparam int NBR_W          = 4;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} lats_op_t;

	// Per-cycle commands broadcast to every row cell.
	typedef struct packed {
		logic shift;
		logic head_load;
		logic wr_en;
		logic wr_val;
	} lats_cell_ctrl_t;

endpackage

### hw/rtl/lats_row_rule.sv
// Next-generation logic for one grid row under rule B3/S23 with wrap in x.
// Depends on lats_pkg for the birth and survival counts.
module lats_row_rule import lats_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic [MAX_WIDTH-1:0]                 up_row,
	input  logic [MAX_WIDTH-1:0]                 mid_row,
	input  logic [MAX_WIDTH-1:0]                 down_row,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]       width,
	output logic [MAX_WIDTH-1:0]                 next_row,
	output logic [MAX_WIDTH-1:0]                 active
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = $clog2(MAX_WIDTH);

	logic [XW-1:0] last_col;

	assign last_col = XW'(width - WW'(1));

	for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
		localparam int XR = (x + 1) % MAX_WIDTH;
		localparam int XL = (x == 0) ? 0 : x - 1;
		localparam logic [WW-1:0] XPOS = WW'(x);
		localparam logic [XW-1:0] XIDX = XW'(x);

		logic             at_last;
		logic             ul, ml, dl, ur, mr, dr;
		logic [NBR_W-1:0] count;

		assign at_last = (XIDX == last_col);

		// Left neighbor wraps to the last active column.
		if (x == 0) begin : g_wrap_l
			assign ul = up_row[last_col];
			assign ml = mid_row[last_col];
			assign dl = down_row[last_col];
		end else begin : g_plain_l
			assign ul = up_row[XL];
			assign ml = mid_row[XL];
			assign dl = down_row[XL];
		end

		// Right neighbor wraps to column zero on the last active column.
		assign ur = at_last ? up_row[0]   : up_row[XR];
		assign mr = at_last ? mid_row[0]  : mid_row[XR];
		assign dr = at_last ? down_row[0] : down_row[XR];

		assign count = NBR_W'(ul) + NBR_W'(up_row[x]) + NBR_W'(ur)
			+ NBR_W'(ml) + NBR_W'(mr)
			+ NBR_W'(dl) + NBR_W'(down_row[x]) + NBR_W'(dr);

		assign active[x]   = (XPOS < width);
		assign next_row[x] = active[x]
			? ((count == NBR_W'(BIRTH_COUNT))
				|| ((count == NBR_W'(SURVIVE_COUNT)) && mid_row[x]))
			: mid_row[x];
	end

endmodule

### hw/rtl/lats_row_cell.sv
// One link of the row ring: holds one grid row and its snapshot row.
// Depends on lats_pkg for the control struct.
module lats_row_cell import lats_pkg::*; #(
	parameter int CELL_INDEX = 0,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lats_cell_ctrl_t                      ctrl,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]      height,
	input  logic [$clog2(MAX_HEIGHT)-1:0]        wr_row,
	input  logic [$clog2(MAX_WIDTH)-1:0]         wr_col,
	input  logic [MAX_WIDTH-1:0]                 next_grid,
	input  logic [MAX_WIDTH-1:0]                 next_snap,
	input  logic [MAX_WIDTH-1:0]                 tail_grid,
	input  logic [MAX_WIDTH-1:0]                 tail_snap,
	output logic [MAX_WIDTH-1:0]                 grid_row,
	output logic [MAX_WIDTH-1:0]                 snap_row
);

	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int HIW = $clog2(MAX_HEIGHT);
	localparam logic [HW-1:0]  POS     = HW'(CELL_INDEX);
	localparam logic [HIW-1:0] POS_IDX = HIW'(CELL_INDEX);
	localparam bit             IS_HEAD = (CELL_INDEX == 0);

	logic [MAX_WIDTH-1:0] grid_q;
	logic [MAX_WIDTH-1:0] snap_q;
	logic                 in_ring;
	logic                 is_tail;

	assign in_ring = (POS < height);
	assign is_tail = (POS == height - HW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= '0;
			snap_q <= '0;
		end else if (ctrl.shift && in_ring) begin
			// The tail closes the ring; everyone else takes the next row up the chain.
			grid_q <= is_tail ? tail_grid : next_grid;
			snap_q <= is_tail ? tail_snap : next_snap;
		end else if (ctrl.head_load && IS_HEAD) begin
			grid_q <= tail_grid;
			snap_q <= tail_snap;
		end else if (ctrl.wr_en && (wr_row == POS_IDX)) begin
			grid_q[wr_col] <= ctrl.wr_val;
			snap_q[wr_col] <= ctrl.wr_val;
		end
	end

	assign grid_row = grid_q;
	assign snap_row = snap_q;

endmodule

### hw/rtl/life_automaton_torus_step.sv
// Life automaton (B3/S23) on a wrapping grid, with change detection against a snapshot.
// Depends on lats_pkg, lats_row_cell, lats_row_rule and the assertion macro header.
`include "life_automaton_torus_step_assert.svh"

// The grid lives in a ring of MAX_HEIGHT row cells; each cell holds one grid row
// and the matching snapshot row, and row r sits in cell r between items. A step
// rotates the active part of the ring (grid_height rows) one row per cycle: the
// head cell feeds the row rule, whose result re-enters the ring at the tail, so
// after a full turn every row is back in its home cell. Row 0 is passed through
// unchanged on the first cycle and rewritten in place after the turn, once the
// old last row is known. The snapshot ring turns alongside and takes the new rows
// except on every tenth generation. A step sweeps the h active rows (h the clamped
// grid height), fixes row 0 and then posts its result; an in-range read also turns
// the ring and then posts; writes, out-of-range reads and the unused code post
// their result directly. A new item is taken whenever the block is idle, even
// while the last result waits.
module life_automaton_torus_step import lats_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_write,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic               cell_value,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               cell_out,
	output logic               changed
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int HIW  = $clog2(MAX_HEIGHT);
	localparam int CWW  = (WW > CFG_W) ? WW : CFG_W;
	localparam int CHW  = (HW > CFG_W) ? HW : CFG_W;
	localparam int CXW  = (WW > COORD_W) ? WW : COORD_W;
	localparam int CYW  = (HW > COORD_W) ? HW : COORD_W;
	localparam logic [GEN_W-1:0] GEN_LAST = GEN_W'(GEN_PERIOD - 1);

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_FIX,
		S_POST
	} state_t;

	// Configuration registers
	logic [CFG_W-1:0] grid_width_q;
	logic [CFG_W-1:0] grid_height_q;

	// Control and item state
	state_t            state_q;
	lats_op_t          op_q;
	logic [COORD_W-1:0] row_q;
	logic [XW-1:0]     col_q;
	logic [HW-1:0]     cnt_q;
	logic [GEN_W-1:0]  gen_q;
	logic              tenth_q;
	logic              diff_q;
	logic              rd_bit_q;
	logic              out_valid_q;
	logic              cell_out_q;
	logic              changed_q;
	logic [MAX_WIDTH-1:0] prev_q;
	logic [MAX_WIDTH-1:0] row1_q;

	// Ring taps
	logic [MAX_WIDTH-1:0] grid_w [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] snap_w [MAX_HEIGHT];

	logic [CWW-1:0]       wcfg;
	logic [CHW-1:0]       hcfg;
	logic [WW-1:0]        w_eff;
	logic [HW-1:0]        h_eff;
	logic [HW-1:0]        h_last;
	lats_op_t             op_in;
	logic                 col_ok;
	logic                 row_ok;
	logic                 accept;
	logic                 last_row;
	logic                 rewrite;
	logic                 row_hit;
	logic                 diff_hit;
	lats_cell_ctrl_t      cell_ctrl;
	logic [MAX_WIDTH-1:0] down_row;
	logic [MAX_WIDTH-1:0] new_row;
	logic [MAX_WIDTH-1:0] act_mask;
	logic [MAX_WIDTH-1:0] snap_new;
	logic [MAX_WIDTH-1:0] tail_grid;
	logic [MAX_WIDTH-1:0] tail_snap;

	// Clamp the configured size into [MIN_SIZE, MAX]
	assign wcfg  = CWW'(grid_width_q);
	assign hcfg  = CHW'(grid_height_q);
	assign w_eff = (wcfg < CWW'(MIN_SIZE))  ? WW'(MIN_SIZE)
		: (wcfg > CWW'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(wcfg);
	assign h_eff = (hcfg < CHW'(MIN_SIZE))  ? HW'(MIN_SIZE)
		: (hcfg > CHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(hcfg);
	assign h_last = h_eff - HW'(1);

	assign op_in  = lats_op_t'(operation);
	assign col_ok = (CXW'(column) < CXW'(w_eff));
	assign row_ok = (CYW'(row) < CYW'(h_eff));
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign last_row = (cnt_q == h_last);
	assign row_hit  = (CYW'(cnt_q) == CYW'(row_q));
	// Rows 1..h-1 are rewritten on their way to the tail; row 0 in place afterward.
	assign rewrite  = (op_q == OP_STEP)
		&& (((state_q == S_SWEEP) && (cnt_q != '0)) || (state_q == S_FIX));

	// The row below is the next cell, except for row 0, whose old neighbor was saved.
	assign down_row = (state_q == S_FIX) ? row1_q : grid_w[1];

	lats_row_rule #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_rule (
		.up_row  (prev_q),
		.mid_row (grid_w[0]),
		.down_row(down_row),
		.width   (w_eff),
		.next_row(new_row),
		.active  (act_mask)
	);

	// Snapshot follows the grid unless this is the tenth generation.
	assign snap_new  = tenth_q ? snap_w[0]
		: ((snap_w[0] & ~act_mask) | (new_row & act_mask));
	assign diff_hit  = |((new_row ^ snap_w[0]) & act_mask);
	assign tail_grid = rewrite ? new_row  : grid_w[0];
	assign tail_snap = rewrite ? snap_new : snap_w[0];

	assign cell_ctrl.shift     = (state_q == S_SWEEP);
	assign cell_ctrl.head_load = (state_q == S_FIX);
	assign cell_ctrl.wr_en     = accept && (op_in == OP_WRITE) && col_ok && row_ok;
	assign cell_ctrl.wr_val    = cell_value;

	for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_cell
		lats_row_cell #(
			.CELL_INDEX(i),
			.MAX_WIDTH (MAX_WIDTH),
			.MAX_HEIGHT(MAX_HEIGHT)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.height   (h_eff),
			.wr_row   (HIW'(row)),
			.wr_col   (XW'(column)),
			.next_grid(grid_w[(i + 1) % MAX_HEIGHT]),
			.next_snap(snap_w[(i + 1) % MAX_HEIGHT]),
			.tail_grid(tail_grid),
			.tail_snap(tail_snap),
			.grid_row (grid_w[i]),
			.snap_row (snap_w[i])
		);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_W'(GRID_RESET);
			grid_height_q <= CFG_W'(GRID_RESET);
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default:         grid_width_q  <= grid_width_q;
			endcase
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NONE;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			gen_q       <= '0;
			tenth_q     <= 1'b0;
			diff_q      <= 1'b0;
			rd_bit_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cell_out_q  <= 1'b0;
			changed_q   <= 1'b0;
			prev_q      <= '0;
			row1_q      <= '0;
		end else begin
			// Drop the result once taken; in S_POST the result register is handled below.
			if (out_valid_q && out_ready && (state_q != S_POST)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= op_in;
						row_q    <= row;
						col_q    <= XW'(column);
						cnt_q    <= '0;
						diff_q   <= 1'b0;
						rd_bit_q <= 1'b0;
						unique case (op_in)
							OP_WRITE: begin
								gen_q   <= '0;
								state_q <= S_POST;
							end
							OP_STEP: begin
								gen_q   <= (gen_q == GEN_LAST) ? '0 : gen_q + GEN_W'(1);
								tenth_q <= (gen_q == GEN_LAST);
								state_q <= S_SWEEP;
							end
							OP_READ: begin
								state_q <= (col_ok && row_ok) ? S_SWEEP : S_POST;
							end
							OP_NONE: begin
								state_q <= S_POST;
							end
							default: state_q <= S_POST;
						endcase
					end
				end
				S_SWEEP: begin
					cnt_q  <= cnt_q + HW'(1);
					// Hold the old head row: it is the upper neighbor of the next one.
					prev_q <= grid_w[0];
					if (cnt_q == '0) begin
						row1_q <= grid_w[1];
					end
					if (rewrite && diff_hit) begin
						diff_q <= 1'b1;
					end
					if ((op_q == OP_READ) && row_hit) begin
						rd_bit_q <= grid_w[0][col_q];
					end
					if (last_row) begin
						state_q <= (op_q == OP_STEP) ? S_FIX : S_POST;
					end
				end
				S_FIX: begin
					if (diff_hit) begin
						diff_q <= 1'b1;
					end
					state_q <= S_POST;
				end
				S_POST: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						cell_out_q  <= (op_q == OP_READ) && rd_bit_q;
						changed_q   <= (op_q == OP_STEP) && (tenth_q || diff_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign cell_out  = cell_out_q;
	assign changed   = changed_q;

	`LATS_ASSERT(sweep_cnt_in_ring, state_q == S_SWEEP, cnt_q < h_eff, "sweep count past ring")
	`LATS_ASSERT(fix_after_full_turn, state_q == S_FIX, $past(state_q == S_SWEEP && last_row), "row 0 fixed before full turn")
	`LATS_ASSERT_NEXT(fix_then_post, state_q == S_FIX, state_q == S_POST, "fix not followed by post")
	`LATS_ASSERT(gen_below_period, out_valid_q || !out_valid_q, gen_q <= GEN_LAST, "generation count out of range")

endmodule
